// ----- hw/rtl/bffa_pkg.sv -----
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared widths, operation and status codes and types of the block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  // request and result field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned BYTES_W  = 27;
  localparam int unsigned OFFS_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned AOFF_W   = 26;
  localparam int unsigned CNT_W    = 9;
  localparam int unsigned FRAG_W   = 7;

  // pool defaults
  localparam int unsigned DEF_POOL_BLOCKS = 256;
  localparam int unsigned DEF_BLOCK_LOG2  = 18;

  // percent scale
  localparam int unsigned PCT = 100;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STATS = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RSVD  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- hw/rtl/bffa_ram.sv -----
// ----------------------------------------------------------------------------
// bffa_ram
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 1,
  parameter int unsigned AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/bffa_div.sv -----
// ----------------------------------------------------------------------------
// bffa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bffa_div import bffa_pkg::*; #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quot_o,
  output div_stat_t        stat_o
);

  localparam int unsigned IW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [IW-1:0]    cnt_q;
  logic [NUM_W-1:0] num_q, quot_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [DEN_W:0]   rem_sh, diff;
  logic             ge;

  // one trial subtraction
  always_comb begin
    rem_sh = {rem_q, num_q[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    ge     = (rem_sh >= {1'b0, den_q});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= IW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == IW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      num_q  <= {num_q[NUM_W-2:0], 1'b0};
      rem_q  <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quot_q <= {quot_q[NUM_W-2:0], ge};
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- hw/rtl/bitmap_first_fit_block_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator
// First-fit contiguous block allocator over a used bitmap and run-length table.
// ----------------------------------------------------------------------------
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+--------------------------------------
//  in      | in_valid_i  | in_stall_o   | func_i, alloc_bytes_i, free_offset_i
//  out     | out_valid_o | out_stall_i  | status_o .. fragmentation_percent_o
//
//  allocate: a first-fit scan of the bitmap, then the run is marked used block by block
//  free: a run-length lookup, then the run is cleared block by block; statistics: a bitmap scan, then a divide
//  the scans read the bitmap through its single read port, one block per cycle
//  after reset both memories are cleared entry by entry, with in_stall_o high
//  a result waiting on out_stall_i holds back the result of the next request
// ----------------------------------------------------------------------------
module bitmap_first_fit_block_allocator import bffa_pkg::*; #(
  parameter int unsigned POOL_BLOCKS      = DEF_POOL_BLOCKS,
  parameter int unsigned BLOCK_BYTES_LOG2 = DEF_BLOCK_LOG2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [FUNC_W-1:0]   func_i,
  input  logic [BYTES_W-1:0]  alloc_bytes_i,
  input  logic [OFFS_W-1:0]   free_offset_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [AOFF_W-1:0]   alloc_offset_o,
  output logic [CNT_W-1:0]    free_blocks_o,
  output logic [CNT_W-1:0]    used_blocks_o,
  output logic [CNT_W-1:0]    largest_free_run_o,
  output logic [FRAG_W-1:0]   fragmentation_percent_o
);

  localparam int unsigned AW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(POOL_BLOCKS + 1);
  localparam int unsigned NW = CW + FRAG_W;
  localparam logic [CW-1:0] N_C = CW'(POOL_BLOCKS);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_A_SCAN, S_A_FILL, S_F_ISSUE, S_F_CHECK,
    S_F_CLEAR, S_S_SCAN, S_S_DIV, S_RESP
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       idx_q, cnt_q, start_q, need_q, rem_q;
  logic [CW-1:0]       freeb_q, run_q, best_q;
  logic [AW-1:0]       chk_q, blk_q;
  logic                pend_q, stats_q;
  logic [STATUS_W-1:0] r_status_q;
  logic [AOFF_W-1:0]   r_aoff_q;
  logic [FRAG_W-1:0]   r_frag_q;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [AOFF_W-1:0]   aoff_q;
  logic [CNT_W-1:0]    freeb_o_q, used_o_q, best_o_q;
  logic [FRAG_W-1:0]   frag_o_q;

  // memory ports
  logic          used_we, used_wdata, used_rdata;
  logic [AW-1:0] used_waddr, used_raddr;
  logic          rl_we;
  logic [AW-1:0] rl_waddr, rl_raddr;
  logic [CW-1:0] rl_wdata, rl_rdata;

  // divider
  logic          div_start;
  logic [NW-1:0] div_num, div_quot;
  div_stat_t     div_st;

  // request decode
  logic [BYTES_W:0] need_full;
  logic [63:0]      free_limit, free_off_w, start_off;
  logic             free_bad;
  logic [CW-1:0]    cnt_inc, run_inc;

  always_comb begin
    need_full  = ({1'b0, alloc_bytes_i} + (BYTES_W+1)'((64'd1 << BLOCK_BYTES_LOG2) - 64'd1))
                 >> BLOCK_BYTES_LOG2;
    free_limit = 64'(POOL_BLOCKS) << BLOCK_BYTES_LOG2;
    free_off_w = 64'(free_offset_i);
    free_bad   = (free_off_w >= free_limit) ||
                 ((free_off_w & ((64'd1 << BLOCK_BYTES_LOG2) - 64'd1)) != 64'd0);
    start_off  = 64'(start_q) << BLOCK_BYTES_LOG2;
    cnt_inc    = cnt_q + 1'b1;
    run_inc    = run_q + 1'b1;
  end

  // memory control
  always_comb begin
    used_raddr = idx_q[AW-1:0];
    used_waddr = idx_q[AW-1:0];
    used_wdata = (state_q == S_A_FILL);
    used_we    = (state_q == S_CLEAR) || (state_q == S_A_FILL) ||
                 ((state_q == S_F_CLEAR) && (rem_q != '0) && (idx_q != N_C));
    rl_raddr   = blk_q;
    rl_we      = (state_q == S_CLEAR) ||
                 ((state_q == S_A_FILL) && (idx_q == start_q)) ||
                 ((state_q == S_F_CHECK) && (rl_rdata != '0));
    rl_waddr   = blk_q;
    rl_wdata   = '0;
    if (state_q == S_CLEAR) begin
      rl_waddr = idx_q[AW-1:0];
    end else if (state_q == S_A_FILL) begin
      rl_waddr = start_q[AW-1:0];
      rl_wdata = need_q;
    end
  end

  bffa_ram #(.DEPTH(POOL_BLOCKS), .WIDTH(1), .AW(AW)) u_used (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .raddr_i (used_raddr),
    .rdata_o (used_rdata)
  );

  bffa_ram #(.DEPTH(POOL_BLOCKS), .WIDTH(CW), .AW(AW)) u_runlen (
    .clk_i   (clk_i),
    .we_i    (rl_we),
    .waddr_i (rl_waddr),
    .wdata_i (rl_wdata),
    .raddr_i (rl_raddr),
    .rdata_o (rl_rdata)
  );

  // fragmentation divide
  assign div_start = (state_q == S_S_SCAN) && !pend_q && (idx_q == N_C);
  assign div_num   = NW'(freeb_q - best_q) * NW'(PCT);

  bffa_div #(.NUM_W(NW), .DEN_W(CW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (freeb_q),
    .quot_o  (div_quot),
    .stat_o  (div_st)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == N_C - 1'b1) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid_i) begin
            r_aoff_q <= '0;
            r_frag_q <= '0;
            stats_q  <= 1'b0;
            idx_q    <= '0;
            pend_q   <= 1'b0;
            cnt_q    <= '0;
            start_q  <= '0;
            freeb_q  <= '0;
            run_q    <= '0;
            best_q   <= '0;
            case (func_i)
              FUNC_ALLOC: begin
                if (alloc_bytes_i == '0) begin
                  r_status_q <= ST_ZERO;
                  state_q    <= S_RESP;
                end else if (need_full > (BYTES_W+1)'(POOL_BLOCKS)) begin
                  r_status_q <= ST_NOSPACE;
                  state_q    <= S_RESP;
                end else begin
                  need_q  <= CW'(need_full);
                  state_q <= S_A_SCAN;
                end
              end
              FUNC_FREE: begin
                blk_q <= AW'(free_off_w >> BLOCK_BYTES_LOG2);
                if (free_bad) begin
                  r_status_q <= ST_IGNORED;
                  state_q    <= S_RESP;
                end else begin
                  state_q <= S_F_ISSUE;
                end
              end
              FUNC_STATS: begin
                stats_q    <= 1'b1;
                r_status_q <= ST_DONE;
                state_q    <= S_S_SCAN;
              end
              default: begin
                r_status_q <= ST_IGNORED;
                state_q    <= S_RESP;
              end
            endcase
          end
        end
        S_A_SCAN: begin
          // issue one bitmap read a cycle, check the one returned
          if (idx_q != N_C) begin
            idx_q <= idx_q + 1'b1;
          end
          pend_q <= (idx_q != N_C);
          chk_q  <= idx_q[AW-1:0];
          if (pend_q) begin
            if (used_rdata) begin
              cnt_q   <= '0;
              start_q <= CW'(chk_q) + 1'b1;
            end else if (cnt_inc == need_q) begin
              r_status_q <= ST_DONE;
              r_aoff_q   <= start_off[AOFF_W-1:0];
              idx_q      <= start_q;
              rem_q      <= need_q;
              state_q    <= S_A_FILL;
            end else begin
              cnt_q <= cnt_inc;
            end
          end else if (idx_q == N_C) begin
            r_status_q <= ST_NOSPACE;
            state_q    <= S_RESP;
          end
        end
        S_A_FILL: begin
          idx_q <= idx_q + 1'b1;
          rem_q <= rem_q - 1'b1;
          if (rem_q == CW'(1)) begin
            state_q <= S_RESP;
          end
        end
        S_F_ISSUE: begin
          state_q <= S_F_CHECK;
        end
        S_F_CHECK: begin
          if (rl_rdata == '0) begin
            r_status_q <= ST_IGNORED;
            state_q    <= S_RESP;
          end else begin
            r_status_q <= ST_DONE;
            rem_q      <= rl_rdata;
            idx_q      <= CW'(blk_q);
            state_q    <= S_F_CLEAR;
          end
        end
        S_F_CLEAR: begin
          if ((rem_q == '0) || (idx_q == N_C)) begin
            state_q <= S_RESP;
          end else begin
            idx_q <= idx_q + 1'b1;
            rem_q <= rem_q - 1'b1;
          end
        end
        S_S_SCAN: begin
          if (idx_q != N_C) begin
            idx_q <= idx_q + 1'b1;
          end
          pend_q <= (idx_q != N_C);
          if (pend_q) begin
            if (used_rdata) begin
              run_q <= '0;
            end else begin
              freeb_q <= freeb_q + 1'b1;
              run_q   <= run_inc;
              if (run_inc > best_q) begin
                best_q <= run_inc;
              end
            end
          end else if (idx_q == N_C) begin
            state_q <= S_S_DIV;
          end
        end
        S_S_DIV: begin
          if (div_st.done) begin
            r_frag_q <= (freeb_q == '0) ? '0 : FRAG_W'(div_quot);
            state_q  <= S_RESP;
          end
        end
        S_RESP: begin
          // result register frees up when the old result is taken
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            status_q    <= r_status_q;
            aoff_q      <= r_aoff_q;
            freeb_o_q   <= stats_q ? CNT_W'(freeb_q) : '0;
            used_o_q    <= stats_q ? CNT_W'(N_C - freeb_q) : '0;
            best_o_q    <= stats_q ? CNT_W'(best_q) : '0;
            frag_o_q    <= r_frag_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o              = (state_q != S_IDLE);
  assign out_valid_o             = out_valid_q;
  assign status_o                = status_q;
  assign alloc_offset_o          = aoff_q;
  assign free_blocks_o           = freeb_o_q;
  assign used_blocks_o           = used_o_q;
  assign largest_free_run_o      = best_o_q;
  assign fragmentation_percent_o = frag_o_q;

`ifndef ASSERT_OFF
  // no request taken while the memories are being cleared
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> in_stall_o)
    else $error("request accepted during clearing pass");

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block not busy after accepting a request");

  // bitmap is never written while it is being scanned
  a_no_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_A_SCAN) || (state_q == S_S_SCAN)) |-> !used_we)
    else $error("bitmap write during scan");

  // divider finishes only while the sequencer waits on it
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == S_S_DIV))
    else $error("divider done outside of divide state");
`endif

endmodule
